### src/smpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet tracker package
// Shared types and constants for the packet decoder and the event queue.
// ----------------------------------------------------------------------------
package smpt_pkg;

    localparam int COORD_W = 12;
    localparam int BYTE_W  = 8;
    localparam int NUM_EVT = 3;
    localparam int CNT_W   = 2;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_WARP = 1'b1;

    localparam int HDR_MARK_BIT  = 6;
    localparam int LEFT_HDR_BIT  = 5;
    localparam int RIGHT_HDR_BIT = 4;

    localparam logic [1:0] SEEN_NONE   = 2'd0;
    localparam logic [1:0] SEEN_HEADER = 2'd1;
    localparam logic [1:0] SEEN_SECOND = 2'd2;

    localparam logic [1:0] EV_MOVE = 2'd0;
    localparam logic [1:0] EV_DOWN = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;

    localparam logic [COORD_W-1:0] RST_WIDTH   = 12'd640;
    localparam logic [COORD_W-1:0] RST_HEIGHT  = 12'd480;
    localparam logic [COORD_W-1:0] RST_POINT_X = 12'd320;
    localparam logic [COORD_W-1:0] RST_POINT_Y = 12'd240;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] btn;
    } t_evt;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        t_evt [NUM_EVT-1:0] evts;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_burst;

endpackage

### src/smpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet tracker channels
// Valid/ready channels for input items and for pointer events.
// ----------------------------------------------------------------------------
interface smpt_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  rx_byte;
    logic [11:0] warp_x;
    logic [11:0] warp_y;

    modport source (output valid, func, rx_byte, warp_x, warp_y, input ready);
    modport sink   (input valid, func, rx_byte, warp_x, warp_y, output ready);
endinterface

interface smpt_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [1:0]  which_button;
    logic        last;

    modport source (output valid, event_kind, pos_x, pos_y, which_button, last,
                    input ready);
    modport sink   (input valid, event_kind, pos_x, pos_y, which_button, last,
                    output ready);
endinterface

### src/smpt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder
// Holds the packet and pointer state and computes the events of one item.
// ----------------------------------------------------------------------------
module smpt_core import smpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic               i_func,
    input  logic [BYTE_W-1:0]  i_rx_byte,
    input  logic [COORD_W-1:0] i_warp_x,
    input  logic [COORD_W-1:0] i_warp_y,
    input  logic               i_enabled,
    input  logic [COORD_W-1:0] i_width,
    input  logic [COORD_W-1:0] i_height,
    output t_burst             o_burst
);

    logic [COORD_W-1:0] r_px, n_px;
    logic [COORD_W-1:0] r_py, n_py;
    logic [1:0]         r_held, n_held;
    logic [BYTE_W-1:0]  r_hdr, n_hdr;
    logic [BYTE_W-1:0]  r_b1, n_b1;
    logic [1:0]         r_seen, n_seen;

    logic [COORD_W-1:0] hi_x, hi_y;
    logic [7:0]         dx, dy;
    logic [13:0]        sum_x, sum_y;
    logic [COORD_W-1:0] clamp_x, clamp_y;
    logic [1:0]         new_btn;
    t_evt [NUM_EVT-1:0] cand;
    logic [NUM_EVT-1:0] cand_ok;
    logic [CNT_W-1:0]   cnt;

    assign hi_x = (i_width == '0) ? '0 : i_width - 12'd1;
    assign hi_y = (i_height == '0) ? '0 : i_height - 12'd1;

    assign dx = {r_hdr[1:0], r_b1[5:0]};
    assign dy = {r_hdr[3:2], i_rx_byte[5:0]};

    assign sum_x = {2'b00, r_px} + {{5{dx[7]}}, dx, 1'b0};
    assign sum_y = {2'b00, r_py} + {{5{dy[7]}}, dy, 1'b0};

    always_comb begin
        if (sum_x[13]) begin
            clamp_x = '0;
        end else if (sum_x[12:0] > {1'b0, hi_x}) begin
            clamp_x = hi_x;
        end else begin
            clamp_x = sum_x[11:0];
        end
        if (sum_y[13]) begin
            clamp_y = '0;
        end else if (sum_y[12:0] > {1'b0, hi_y}) begin
            clamp_y = hi_y;
        end else begin
            clamp_y = sum_y[11:0];
        end
    end

    assign new_btn = {r_hdr[RIGHT_HDR_BIT], r_hdr[LEFT_HDR_BIT]};

    always_comb begin
        cand[0].kind = EV_MOVE;
        cand[0].btn  = BTN_NONE;
        cand[1].kind = new_btn[0] ? EV_DOWN : EV_UP;
        cand[1].btn  = BTN_LEFT;
        cand[2].kind = new_btn[1] ? EV_DOWN : EV_UP;
        cand[2].btn  = BTN_RIGHT;
        cand_ok[0]   = (clamp_x != r_px) || (clamp_y != r_py);
        cand_ok[1]   = new_btn[0] != r_held[0];
        cand_ok[2]   = new_btn[1] != r_held[1];
    end

    always_comb begin
        n_px   = r_px;
        n_py   = r_py;
        n_held = r_held;
        n_hdr  = r_hdr;
        n_b1   = r_b1;
        n_seen = r_seen;
        cnt    = '0;
        o_burst       = '0;
        o_burst.x     = r_px;
        o_burst.y     = r_py;
        if (i_fire && i_enabled) begin
            if (i_func == FUNC_WARP) begin
                if (i_warp_x <= hi_x) begin
                    n_px = i_warp_x;
                end
                if (i_warp_y <= hi_y) begin
                    n_py = i_warp_y;
                end
            end else if (i_rx_byte[HDR_MARK_BIT]) begin
                n_hdr  = i_rx_byte;
                n_seen = SEEN_HEADER;
            end else if (r_seen == SEEN_HEADER) begin
                n_b1   = i_rx_byte;
                n_seen = SEEN_SECOND;
            end else if (r_seen == SEEN_SECOND) begin
                n_seen = SEEN_NONE;
                n_px   = clamp_x;
                n_py   = clamp_y;
                n_held = new_btn;
                for (int k = 0; k < NUM_EVT; k++) begin
                    if (cand_ok[k]) begin
                        o_burst.evts[cnt] = cand[k];
                        cnt = cnt + 2'd1;
                    end
                end
                o_burst.count = cnt;
                o_burst.x     = clamp_x;
                o_burst.y     = clamp_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= RST_POINT_X;
            r_py   <= RST_POINT_Y;
            r_held <= '0;
            r_hdr  <= '0;
            r_b1   <= '0;
            r_seen <= SEEN_NONE;
        end else begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_held <= n_held;
            r_hdr  <= n_hdr;
            r_b1   <= n_b1;
            r_seen <= n_seen;
        end
    end

endmodule

### src/smpt_evq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse event queue
// Registers the events of one item and presents them one per transaction.
// ----------------------------------------------------------------------------
module smpt_evq import smpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_burst             i_burst,
    input  logic               i_out_ready,
    output logic               o_can_load,
    output logic               o_valid,
    output t_evt               o_evt,
    output logic [COORD_W-1:0] o_x,
    output logic [COORD_W-1:0] o_y,
    output logic               o_last
);

    logic [CNT_W-1:0]   r_cnt;
    t_evt [NUM_EVT-1:0] r_evts;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               out_fire;

    assign o_valid    = r_cnt != '0;
    assign out_fire   = o_valid && i_out_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == 2'd1) && i_out_ready);
    assign o_evt      = r_evts[0];
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_last     = r_cnt == 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evts <= i_burst.evts;
            r_x    <= i_burst.x;
            r_y    <= i_burst.y;
        end else if (out_fire) begin
            r_evts[0] <= r_evts[1];
            r_evts[1] <= r_evts[2];
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && i_out_ready)))
        else $error("A transaction was loaded over pending events.");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1 && i_out_ready && !i_load) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("The event count did not step down after a transaction.");

    a_move_no_button: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_evts[0].kind == EV_MOVE) |-> (r_evts[0].btn == BTN_NONE))
        else $error("A move event carries a button.");

endmodule

### src/serial_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// Events: the first event of an item is offered in the cycle after the item is accepted.
// Throughput: one item per cycle while items give at most one event and the event
// sink is ready; an item with more events holds the event queue until its last is taken.
// Reset: pointer at 320,240, buttons released, no packet open, block disabled,
// screen 640 by 480, event queue empty.
// ----------------------------------------------------------------------------
// Serial mouse packet tracker
// Decodes three-byte serial mouse packets, applies warp commands and emits pointer and button events.
// ----------------------------------------------------------------------------
module serial_mouse_packet_tracker import smpt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smpt_item_if.sink           i_item,
    smpt_event_if.source        o_event,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [COORD_W-1:0]  i_cfg_data
);

    logic               r_enabled;
    logic [COORD_W-1:0] r_width;
    logic [COORD_W-1:0] r_height;
    logic               in_fire;
    logic               can_load;
    t_burst             burst;
    t_evt               evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_width   <= RST_WIDTH;
            r_height  <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLED: r_enabled <= i_cfg_data[0];
                CFG_WIDTH:   r_width   <= i_cfg_data;
                CFG_HEIGHT:  r_height  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_item.ready = can_load;
    assign in_fire      = i_item.valid && can_load;

    smpt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_fire),
        .i_func    (i_item.func),
        .i_rx_byte (i_item.rx_byte),
        .i_warp_x  (i_item.warp_x),
        .i_warp_y  (i_item.warp_y),
        .i_enabled (r_enabled),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_burst   (burst)
    );

    smpt_evq u_evq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_fire),
        .i_burst     (burst),
        .i_out_ready (o_event.ready),
        .o_can_load  (can_load),
        .o_valid     (o_event.valid),
        .o_evt       (evt),
        .o_x         (o_event.pos_x),
        .o_y         (o_event.pos_y),
        .o_last      (o_event.last)
    );

    assign o_event.event_kind   = evt.kind;
    assign o_event.which_button = evt.btn;

endmodule

### tb/serial_mouse_packet_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet tracker testbench
// Feeds serial mouse bytes and warp commands into the tracker under several
// screen settings and checks every move, press and release event it emits.
// The scoreboard tracks the pointer, the buttons and the open packet and
// queues the events that each accepted transaction must cause. Both channel
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module serial_mouse_packet_tracker_tb;
    import smpt_pkg::*;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [1:0]         btn;
        logic               last;
    } t_mouse_event;

    class pointer_event_scoreboard;
        bit                enabled;
        bit [COORD_W-1:0]  scr_w;
        bit [COORD_W-1:0]  scr_h;
        bit [COORD_W-1:0]  ptr_x;
        bit [COORD_W-1:0]  ptr_y;
        bit [1:0]          held;
        bit [BYTE_W-1:0]   header;
        bit [BYTE_W-1:0]   second;
        bit [1:0]          seen;
        t_mouse_event      pending[$];
        int                mismatches;
        int                checked;
        int                moves;
        int                presses;
        int                releases;

        function new();
            enabled = 1'b0;
            scr_w   = RST_WIDTH;
            scr_h   = RST_HEIGHT;
            ptr_x   = RST_POINT_X;
            ptr_y   = RST_POINT_Y;
            held    = 2'b00;
            header  = '0;
            second  = '0;
            seen    = SEEN_NONE;
        endfunction

        function void set_reg(logic [1:0] idx, logic [COORD_W-1:0] val);
            case (idx)
                CFG_ENABLED: enabled = val[0];
                CFG_WIDTH:   scr_w = val;
                CFG_HEIGHT:  scr_h = val;
                default: ;
            endcase
        endfunction

        function int span(bit [COORD_W-1:0] s);
            return (s == 0) ? 1 : int'(s);
        endfunction

        function int clamp(int v, bit [COORD_W-1:0] s);
            if (v < 0) return 0;
            if (v > span(s) - 1) return span(s) - 1;
            return v;
        endfunction

        function void push_event(logic [1:0] kind, logic [1:0] btn);
            t_mouse_event ev;
            ev.kind = kind;
            ev.x    = ptr_x;
            ev.y    = ptr_y;
            ev.btn  = btn;
            ev.last = 1'b0;
            pending.push_back(ev);
        endfunction

        function void apply_item(logic func, logic [BYTE_W-1:0] b,
                                 logic [COORD_W-1:0] wx, logic [COORD_W-1:0] wy);
            byte          sdx;
            byte          sdy;
            int           nx;
            int           ny;
            int           first;
            bit [1:0]     now_held;
            t_mouse_event ev;
            if (!enabled) return;
            if (func == FUNC_WARP) begin
                if (int'(wx) < span(scr_w)) ptr_x = wx;
                if (int'(wy) < span(scr_h)) ptr_y = wy;
                return;
            end
            if (b[HDR_MARK_BIT]) begin
                header = b;
                seen   = SEEN_HEADER;
                return;
            end
            if (seen == SEEN_NONE) return;
            if (seen == SEEN_HEADER) begin
                second = b;
                seen   = SEEN_SECOND;
                return;
            end
            seen  = SEEN_NONE;
            sdx   = {header[1:0], second[5:0]};
            sdy   = {header[3:2], b[5:0]};
            nx    = clamp(int'(ptr_x) + 2 * int'(sdx), scr_w);
            ny    = clamp(int'(ptr_y) + 2 * int'(sdy), scr_h);
            first = pending.size();
            if (nx != int'(ptr_x) || ny != int'(ptr_y)) begin
                ptr_x = nx[COORD_W-1:0];
                ptr_y = ny[COORD_W-1:0];
                push_event(EV_MOVE, BTN_NONE);
                moves++;
            end
            now_held = {header[RIGHT_HDR_BIT], header[LEFT_HDR_BIT]};
            if (now_held[0] != held[0]) begin
                push_event(now_held[0] ? EV_DOWN : EV_UP, BTN_LEFT);
                if (now_held[0]) presses++; else releases++;
            end
            if (now_held[1] != held[1]) begin
                push_event(now_held[1] ? EV_DOWN : EV_UP, BTN_RIGHT);
                if (now_held[1]) presses++; else releases++;
            end
            held = now_held;
            if (pending.size() > first) begin
                ev = pending.pop_back();
                ev.last = 1'b1;
                pending.push_back(ev);
            end
        endfunction

        function void report(string what, t_mouse_event exp, t_mouse_event got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%t: %s: expected kind=%0d x=%0d y=%0d btn=%0d last=%0d, ",
                          "got kind=%0d x=%0d y=%0d btn=%0d last=%0d"},
                         $realtime, what, exp.kind, exp.x, exp.y, exp.btn, exp.last,
                         got.kind, got.x, got.y, got.btn, got.last);
        endfunction

        function void compare_event(t_mouse_event got);
            t_mouse_event exp;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected event", '0, got);
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind || got.x !== exp.x || got.y !== exp.y ||
                got.btn !== exp.btn || got.last !== exp.last)
                report("event mismatch", exp, got);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_idx;
    logic [COORD_W-1:0] cfg_data;

    smpt_item_if  item_if();
    smpt_event_if event_if();

    serial_mouse_packet_tracker u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_event    (event_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pointer_event_scoreboard sb = new();
    int items_sent;
    int warps_sent;
    int settings_used;
    bit sender_calm;
    bit sink_calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d events still expected.", sb.pending.size());
        $display("** serial_mouse_packet_tracker: FAILED **");
        $finish;
    end

    task automatic send_item(logic func, logic [BYTE_W-1:0] b,
                             logic [COORD_W-1:0] wx, logic [COORD_W-1:0] wy);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            item_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        item_if.valid   <= 1'b1;
        item_if.func    <= func;
        item_if.rx_byte <= b;
        item_if.warp_x  <= wx;
        item_if.warp_y  <= wy;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        sb.apply_item(func, b, wx, wy);
        items_sent++;
        if (func == FUNC_WARP) warps_sent++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        send_item(FUNC_BYTE, b, 12'($urandom), 12'($urandom));
    endtask

    task automatic send_packet(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] b1,
                               logic [BYTE_W-1:0] b2);
        send_byte(hdr);
        send_byte(b1);
        send_byte(b2);
    endtask

    task automatic warp(logic [COORD_W-1:0] wx, logic [COORD_W-1:0] wy);
        send_item(FUNC_WARP, 8'($urandom), wx, wy);
    endtask

    task automatic drain();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic en, logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        drain();
        write_reg(CFG_ENABLED, {{(COORD_W-1){1'b0}}, en});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_traffic(int count);
        int target;
        int pick;
        int lim_x;
        int lim_y;
        target = items_sent + count;
        while (items_sent < target) begin
            if ($urandom_range(0, 24) == 0) sender_calm = ~sender_calm;
            if ($urandom_range(0, 24) == 0) sink_calm = ~sink_calm;
            if ($urandom_range(0, 59) == 0) drain();
            pick  = $urandom_range(0, 99);
            lim_x = sb.span(sb.scr_w) - 1;
            lim_y = sb.span(sb.scr_h) - 1;
            if (pick < 70) begin
                send_packet({1'($urandom), 1'b1, 6'($urandom)},
                            {1'($urandom), 1'b0, 6'($urandom)},
                            {1'($urandom), 1'b0, 6'($urandom)});
            end else if (pick < 82) begin
                if ($urandom_range(0, 3) == 0)
                    warp(12'($urandom), 12'($urandom));
                else
                    warp(12'($urandom_range(0, lim_x)), 12'($urandom_range(0, lim_y)));
            end else if (pick < 92) begin
                send_byte(8'($urandom));
            end else begin
                send_byte({1'($urandom), 1'b1, 6'($urandom)});
                send_byte({1'($urandom), 1'b0, 6'($urandom)});
                send_packet({1'($urandom), 1'b1, 6'($urandom)},
                            {1'($urandom), 1'b0, 6'($urandom)},
                            {1'($urandom), 1'b0, 6'($urandom)});
            end
        end
    endtask

    initial begin
        int stall;
        t_mouse_event got;
        event_if.ready = 1'b0;
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 3);
            repeat (stall) begin
                @(negedge i_clk);
                event_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            event_if.ready <= 1'b1;
            do @(posedge i_clk); while (event_if.valid !== 1'b1);
            got.kind = event_if.event_kind;
            got.x    = event_if.pos_x;
            got.y    = event_if.pos_y;
            got.btn  = event_if.which_button;
            got.last = event_if.last;
            sb.compare_event(got);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_ENABLED;
        cfg_data        = '0;
        item_if.valid   = 1'b0;
        item_if.func    = FUNC_BYTE;
        item_if.rx_byte = '0;
        item_if.warp_x  = '0;
        item_if.warp_y  = '0;
        sender_calm     = 1'b0;
        sink_calm       = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block comes out of reset disabled, so this traffic is dropped.
        send_packet(8'h69, 8'h3F, 8'h00);
        warp(12'd5, 12'd5);

        configure(1'b1, 12'd640, 12'd480);
        send_byte(8'h3F);
        send_packet(8'h69, 8'h3F, 8'h00);
        send_byte(8'h40);
        send_packet(8'h53, 8'h00, 8'h3F);
        send_packet(8'h50, 8'h00, 8'h00);
        warp(12'd4095, 12'd100);
        warp(12'd0, 12'd0);
        send_packet(8'hFF, 8'h80, 8'hBF);
        send_packet(8'h43, 8'h00, 8'h00);

        configure(1'b1, 12'd4095, 12'd4095);
        warp(12'd4094, 12'd4094);
        warp(12'd4095, 12'd4095);
        send_packet(8'h45, 8'h3F, 8'h3F);

        // Shrinking the screen leaves the pointer outside until a packet clamps it.
        configure(1'b1, 12'd1, 12'd1);
        warp(12'd1, 12'd1);
        send_packet(8'h40, 8'h00, 8'h00);
        warp(12'd0, 12'd0);

        configure(1'b1, 12'd0, 12'd0);
        warp(12'd3, 12'd0);
        send_packet(8'h60, 8'h01, 8'h02);

        configure(1'b0, 12'd640, 12'd480);
        send_packet(8'h70, 8'h10, 8'h10);

        configure(1'b1, 12'd640, 12'd480);
        random_traffic(36);
        configure(1'b1, 12'd4095, 12'd4095);
        random_traffic(36);
        configure(1'b1, 12'd1, 12'd4095);
        random_traffic(36);
        configure(1'b1, 12'($urandom_range(2, 300)), 12'($urandom_range(2, 300)));
        random_traffic(36);
        configure(1'b1, 12'd4095, 12'd1);
        random_traffic(36);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.mismatches++;
            $display("%0d expected events never arrived.", sb.pending.size());
        end
        $display("Sent %0d transactions (%0d warps) over %0d screen settings.",
                 items_sent, warps_sent, settings_used);
        $display({"Checked %0d events: %0d moves, %0d presses, %0d releases, ",
                  "%0d mismatches."},
                 sb.checked, sb.moves, sb.presses, sb.releases, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("** serial_mouse_packet_tracker: PASSED **");
        end else begin
            $display("** serial_mouse_packet_tracker: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
src/smpt_pkg.sv
src/smpt_if.sv
src/smpt_core.sv
src/smpt_evq.sv
src/serial_mouse_packet_tracker.sv
tb/serial_mouse_packet_tracker_tb.sv
